>>> hdl/bptc_pkg.sv
// ----------------------------------------------------------------------------
// bptc_pkg
// Shared types, constants and Q24 helper functions for the barometric
// temperature / pressure compensation block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bptc_pkg;

  // input word: one raw sensor reading
  typedef struct packed {
    logic       kind;
    logic [7:0] raw_msb;
    logic [7:0] raw_lsb;
    logic [7:0] raw_xlsb;
  } in_word_t;

  // result word
  typedef struct packed {
    logic               result_kind;
    logic signed [31:0] value;
    logic               invalid;
  } out_word_t;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_TA, S_TB, S_TC, S_TFINE, S_TOUT,
    S_P0, S_P1, S_P2, S_P3, S_P4A, S_P4B, S_P5, S_P6, S_P7, S_P8,
    S_P9, S_P10, S_P11, S_P12, S_P13, S_P14, S_P15, S_P16, S_P17,
    S_P18, S_P19, S_P20, S_PFIN,
    S_DONE
  } seq_state_t;

  // register indexes
  localparam logic [1:0] REG_TEMP_COEFFS = 2'd0;
  localparam logic [1:0] REG_PRESS_LOW   = 2'd1;
  localparam logic [1:0] REG_PRESS_HIGH  = 2'd2;
  localparam logic [1:0] REG_PRESS_NINE  = 2'd3;

  // raw skip codes
  localparam logic [19:0] RAW_SKIP_LO = 20'h80000;
  localparam logic [19:0] RAW_SKIP_HI = 20'hFFFFF;

  // Q24 constants
  localparam logic signed [63:0] QMAX      = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] QMAX_W    = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] QMIN_W    = -65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] QONE      = 64'sh0000_0000_0100_0000;
  localparam logic signed [63:0] Q_M64000  = -64'sd64000 * 64'sd16777216;
  localparam logic signed [63:0] Q_6250    = 64'sd6250 * 64'sd16777216;
  localparam logic [20:0]        RAW_FULL  = 21'h100000;

  // build a signed value from sign and magnitude, capped at QMAX
  function automatic logic signed [63:0] q_make(input logic neg, input logic [63:0] m);
    logic [63:0] c;
    c = m[63] ? QMAX : m;
    return neg ? -$signed(c) : $signed(c);
  endfunction

  // power-of-two divide, rounding toward zero
  function automatic logic signed [63:0] q_shr(input logic signed [63:0] a,
                                               input int unsigned k);
    logic [63:0] m;
    m = a[63] ? 64'(-a) : 64'(a);
    return q_make(a[63], m >> k);
  endfunction

  // saturating add to +-QMAX
  function automatic logic signed [63:0] q_add(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > QMAX_W) return QMAX;
    if (s < QMIN_W) return -QMAX;
    return s[63:0];
  endfunction

endpackage

`default_nettype wire

>>> hdl/bptc_mul.sv
// ----------------------------------------------------------------------------
// bptc_mul
// Shared 64x64 sign-magnitude multiplier built from four 32x32 partial
// products; gives the saturated Q24 product and the plain integer product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bptc_mul
  import bptc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [63:0] a,
  input  wire logic signed [63:0] b,
  output logic                    done,
  output logic signed [63:0]      q_res,
  output logic signed [63:0]      int_res
);

  logic [63:0]  ma_r, mb_r;
  logic         neg_r;
  logic [2:0]   step_r;
  logic         busy_r;
  logic         done_r;
  logic [63:0]  pp_r;
  logic [1:0]   pp_idx_r;
  logic         pp_vld_r;
  logic [127:0] acc_r;

  logic [31:0]  a_h, b_h;
  logic [63:0]  pp_nxt;
  logic [1:0]   shf;
  logic [127:0] acc_add;
  logic [63:0]  qm;

  // partial product operand select
  assign a_h    = step_r[1] ? ma_r[63:32] : ma_r[31:0];
  assign b_h    = step_r[0] ? mb_r[63:32] : mb_r[31:0];
  assign pp_nxt = a_h * b_h;
  assign shf    = {1'b0, pp_idx_r[1]} + {1'b0, pp_idx_r[0]};

  // aligned partial product
  always_comb begin
    case (shf)
      2'd0:    acc_add = {64'b0, pp_r};
      2'd1:    acc_add = {32'b0, pp_r, 32'b0};
      default: acc_add = {pp_r, 64'b0};
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      done_r   <= 1'b0;
      pp_vld_r <= 1'b0;
      step_r   <= '0;
    end else begin
      done_r <= busy_r && (step_r == 3'd4);
      if (start) begin
        busy_r   <= 1'b1;
        step_r   <= '0;
        pp_vld_r <= 1'b0;
      end else if (busy_r) begin
        pp_vld_r <= (step_r != 3'd4);
        if (step_r == 3'd4) busy_r <= 1'b0;
        step_r <= step_r + 3'd1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      ma_r  <= a[63] ? 64'(-a) : 64'(a);
      mb_r  <= b[63] ? 64'(-b) : 64'(b);
      neg_r <= a[63] ^ b[63];
      acc_r <= '0;
    end else if (busy_r) begin
      pp_r     <= pp_nxt;
      pp_idx_r <= step_r[1:0];
      if (pp_vld_r) acc_r <= acc_r + acc_add;
    end
  end

  // result forms
  assign qm      = (|acc_r[127:88]) ? '1 : acc_r[87:24];
  assign q_res   = q_make(neg_r, qm);
  assign int_res = neg_r ? -$signed(acc_r[63:0]) : $signed(acc_r[63:0]);
  assign done    = done_r;

endmodule

`default_nettype wire

>>> hdl/bptc_div.sv
// ----------------------------------------------------------------------------
// bptc_div
// Restoring Q24 divider, one quotient bit a cycle, quotient rounds toward
// zero and saturates at +-QMAX.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bptc_div
  import bptc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [63:0] num,
  input  wire logic signed [63:0] den,
  output logic                    done,
  output logic signed [63:0]      quo
);

  localparam int unsigned DVD_W = 88;
  localparam int unsigned HI_BITS = DVD_W - 64;

  logic             busy_r, done_r, neg_r, ovf_r;
  logic [6:0]       cnt_r;
  logic [DVD_W-1:0] dvd_r;
  logic [63:0]      ud_r, rem_r, quo_r;

  logic [63:0]      rs;
  logic             ge;

  assign rs = {rem_r[62:0], dvd_r[DVD_W-1]};
  assign ge = (rs >= ud_r);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == 7'(DVD_W - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == 7'(DVD_W - 1)) busy_r <= 1'b0;
        cnt_r <= cnt_r + 7'd1;
      end
    end
  end

  // shift-subtract step
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= {(num[63] ? 64'(-num) : 64'(num)), 24'b0};
      ud_r  <= den[63] ? 64'(-den) : 64'(den);
      neg_r <= num[63] ^ den[63];
      rem_r <= '0;
      quo_r <= '0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= ge ? rs - ud_r : rs;
      quo_r <= {quo_r[62:0], ge};
      if (ge && (cnt_r < 7'(HI_BITS))) ovf_r <= 1'b1;
    end
  end

  assign quo  = q_make(neg_r, ovf_r ? '1 : quo_r);
  assign done = done_r;

endmodule

`default_nettype wire

>>> hdl/baro_temp_pressure_compensation_top.sv
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_top
// Raw sensor word in, compensated temperature or pressure word out.
// ----------------------------------------------------------------------------
// Each input word is one raw reading (kind 0 temperature, 1 pressure) and
// gives one result word. A small sequencer runs the calibration formula on one
// shared multiplier (four 32x32 partial products) and one bit-serial divider
// (88 shift-subtract steps). A pressure word ends early on a zero divisor and a
// skip code goes straight to the output; the input stalls while a word is in
// work or waits for the output register. Temperature updates the stored fine
// temperature used by later pressure words. Coefficients are written over the
// APB-style port at byte address 8*index and should be written while no word
// is in work.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module baro_temp_pressure_compensation_top
  import bptc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_word_t    in_data,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_word_t        out_data,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  // Q24 from a 16-bit coefficient
  function automatic logic signed [63:0] sq24(input logic [15:0] v);
    return {{24{v[15]}}, v, 24'b0};
  endfunction

  // configuration registers
  logic [47:0] tc_r;
  logic [63:0] plo_r, phi_r;
  logic [15:0] p9_r;
  logic [1:0]  reg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r  <= '0;
      plo_r <= '0;
      phi_r <= '0;
      p9_r  <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_TEMP_COEFFS: tc_r  <= pwdata[47:0];
        REG_PRESS_LOW:   plo_r <= pwdata;
        REG_PRESS_HIGH:  phi_r <= pwdata;
        REG_PRESS_NINE:  p9_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TEMP_COEFFS: prdata = {16'b0, tc_r};
      REG_PRESS_LOW:   prdata = plo_r;
      REG_PRESS_HIGH:  prdata = phi_r;
      REG_PRESS_NINE:  prdata = {48'b0, p9_r};
      default:         prdata = '0;
    endcase
  end

  // sequencer and working registers
  seq_state_t         state_r, state_nxt;
  logic               issued_r, issued_nxt;
  logic               kind_r, kind_nxt;
  logic [19:0]        raw_r, raw_nxt;
  logic signed [63:0] rx_r, rx_nxt, ry_r, ry_nxt, rq_r, rq_nxt;
  logic signed [63:0] rt_r, rt_nxt, rs_r, rs_nxt, rp_r, rp_nxt;
  logic signed [31:0] fine_r, fine_nxt;
  logic signed [31:0] res_val_r, res_val_nxt;
  logic               res_bad_r, res_bad_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_data_r, out_data_nxt;

  // shared units
  logic               use_mul, use_div, mul_start, div_start;
  logic               mul_done, div_done;
  logic signed [63:0] mul_a, mul_b, mul_q, mul_int, div_q;

  bptc_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .q_res   (mul_q),
    .int_res (mul_int)
  );

  bptc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (rp_r),
    .den   (rx_r),
    .done  (div_done),
    .quo   (div_q)
  );

  logic [19:0]        raw_in;
  logic signed [63:0] fine_w, sum_w;
  logic [20:0]        raw_inv;

  assign raw_in  = {in_data.raw_msb, in_data.raw_lsb, in_data.raw_xlsb[7:4]};
  assign fine_w  = {{32{fine_r[31]}}, fine_r};
  assign raw_inv = RAW_FULL - {1'b0, raw_r};

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // next state and datapath steps
  always_comb begin
    state_nxt     = state_r;
    issued_nxt    = issued_r;
    kind_nxt      = kind_r;
    raw_nxt       = raw_r;
    rx_nxt        = rx_r;
    ry_nxt        = ry_r;
    rq_nxt        = rq_r;
    rt_nxt        = rt_r;
    rs_nxt        = rs_r;
    rp_nxt        = rp_r;
    fine_nxt      = fine_r;
    res_val_nxt   = res_val_r;
    res_bad_nxt   = res_bad_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    use_mul       = 1'b0;
    use_div       = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    sum_w         = '0;

    // result word taken
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt    = in_data.kind;
          raw_nxt     = raw_in;
          res_val_nxt = '0;
          res_bad_nxt = 1'b0;
          if (raw_in == RAW_SKIP_LO || raw_in == RAW_SKIP_HI) begin
            res_bad_nxt = 1'b1;
            state_nxt   = S_DONE;
          end else if (!in_data.kind) begin
            rx_nxt    = $signed({47'b0, raw_in[19:3]}) - $signed({47'b0, tc_r[15:0], 1'b0});
            ry_nxt    = $signed({48'b0, raw_in[19:4]}) - $signed({48'b0, tc_r[15:0]});
            state_nxt = S_TA;
          end else begin
            state_nxt = S_P0;
          end
        end
      end
      // temperature: integer formula
      S_TA: begin
        use_mul = 1'b1;
        mul_a   = rx_r;
        mul_b   = {{48{tc_r[31]}}, tc_r[31:16]};
        if (mul_done) begin rt_nxt = mul_int; state_nxt = S_TB; end
      end
      S_TB: begin
        use_mul = 1'b1;
        mul_a   = ry_r;
        mul_b   = ry_r;
        if (mul_done) begin rq_nxt = mul_int; state_nxt = S_TC; end
      end
      S_TC: begin
        use_mul = 1'b1;
        mul_a   = rq_r >>> 12;
        mul_b   = {{48{tc_r[47]}}, tc_r[47:32]};
        if (mul_done) begin rs_nxt = mul_int; state_nxt = S_TFINE; end
      end
      S_TFINE: begin
        sum_w     = (rt_r >>> 11) + (rs_r >>> 14);
        fine_nxt  = sum_w[31:0];
        state_nxt = S_TOUT;
      end
      S_TOUT: begin
        sum_w       = ((fine_w <<< 2) + fine_w + 64'sd128) >>> 8;
        res_val_nxt = sum_w[31:0];
        state_nxt   = S_DONE;
      end
      // pressure: Q24 formula
      S_P0: begin
        rx_nxt    = q_add(q_shr(fine_w <<< 24, 1), Q_M64000);
        state_nxt = S_P1;
      end
      S_P1: begin
        use_mul = 1'b1;
        mul_a   = rx_r;
        mul_b   = rx_r;
        if (mul_done) begin rt_nxt = mul_q; state_nxt = S_P2; end
      end
      S_P2: begin
        use_mul = 1'b1;
        mul_a   = rt_r;
        mul_b   = sq24(phi_r[31:16]);
        if (mul_done) begin ry_nxt = q_shr(mul_q, 15); state_nxt = S_P3; end
      end
      S_P3: begin
        use_mul = 1'b1;
        mul_a   = rx_r;
        mul_b   = sq24(phi_r[15:0]);
        if (mul_done) begin rs_nxt = mul_q; state_nxt = S_P4A; end
      end
      S_P4A: begin
        rs_nxt    = q_add(rs_r, rs_r);
        state_nxt = S_P4B;
      end
      S_P4B: begin
        ry_nxt    = q_add(ry_r, rs_r);
        state_nxt = S_P5;
      end
      S_P5: begin
        ry_nxt    = q_add(q_shr(ry_r, 2), {{8{plo_r[63]}}, plo_r[63:48], 40'b0});
        state_nxt = S_P6;
      end
      S_P6: begin
        use_mul = 1'b1;
        mul_a   = sq24(plo_r[47:32]);
        mul_b   = rx_r;
        if (mul_done) begin rt_nxt = mul_q; state_nxt = S_P7; end
      end
      S_P7: begin
        use_mul = 1'b1;
        mul_a   = rt_r;
        mul_b   = rx_r;
        if (mul_done) begin rq_nxt = q_shr(mul_q, 19); state_nxt = S_P8; end
      end
      S_P8: begin
        use_mul = 1'b1;
        mul_a   = sq24(plo_r[31:16]);
        mul_b   = rx_r;
        if (mul_done) begin rs_nxt = mul_q; state_nxt = S_P9; end
      end
      S_P9: begin
        rt_nxt    = q_shr(q_add(rq_r, rs_r), 19);
        state_nxt = S_P10;
      end
      S_P10: begin
        rt_nxt    = q_add(QONE, q_shr(rt_r, 15));
        state_nxt = S_P11;
      end
      S_P11: begin
        use_mul = 1'b1;
        mul_a   = rt_r;
        mul_b   = {24'b0, plo_r[15:0], 24'b0};
        if (mul_done) begin
          rx_nxt = mul_q;
          if (mul_q == '0) begin
            res_bad_nxt = 1'b1;
            state_nxt   = S_DONE;
          end else begin
            state_nxt = S_P12;
          end
        end
      end
      S_P12: begin
        rp_nxt    = q_add($signed({19'b0, raw_inv, 24'b0}), -q_shr(ry_r, 12));
        state_nxt = S_P13;
      end
      S_P13: begin
        use_mul = 1'b1;
        mul_a   = rp_r;
        mul_b   = Q_6250;
        if (mul_done) begin rp_nxt = mul_q; state_nxt = S_P14; end
      end
      S_P14: begin
        use_div = 1'b1;
        if (div_done) begin rp_nxt = div_q; state_nxt = S_P15; end
      end
      S_P15: begin
        use_mul = 1'b1;
        mul_a   = sq24(p9_r);
        mul_b   = rp_r;
        if (mul_done) begin rt_nxt = mul_q; state_nxt = S_P16; end
      end
      S_P16: begin
        use_mul = 1'b1;
        mul_a   = rt_r;
        mul_b   = rp_r;
        if (mul_done) begin rq_nxt = q_shr(mul_q, 31); state_nxt = S_P17; end
      end
      S_P17: begin
        use_mul = 1'b1;
        mul_a   = rp_r;
        mul_b   = sq24(phi_r[63:48]);
        if (mul_done) begin rs_nxt = q_shr(mul_q, 15); state_nxt = S_P18; end
      end
      S_P18: begin
        rt_nxt    = q_add(rq_r, rs_r);
        state_nxt = S_P19;
      end
      S_P19: begin
        rt_nxt    = q_add(rt_r, sq24(phi_r[47:32]));
        state_nxt = S_P20;
      end
      S_P20: begin
        rp_nxt    = q_add(rp_r, q_shr(rt_r, 4));
        state_nxt = S_PFIN;
      end
      // Q24.8 with clamp to 0..2^31-1
      S_PFIN: begin
        if (rp_r[63])          res_val_nxt = '0;
        else if (|rp_r[62:47]) res_val_nxt = 32'sh7FFF_FFFF;
        else                   res_val_nxt = $signed({1'b0, rp_r[46:16]});
        state_nxt = S_DONE;
      end
      // hand the word to the output register
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt.result_kind = kind_r;
          out_data_nxt.value       = res_bad_r ? 32'sd0 : res_val_r;
          out_data_nxt.invalid     = res_bad_r;
          out_valid_nxt            = 1'b1;
          state_nxt                = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // one launch per step
    mul_start = use_mul && !issued_r;
    div_start = use_div && !issued_r;
    if (mul_start || div_start) issued_nxt = 1'b1;
    if ((use_mul && mul_done) || (use_div && div_done)) issued_nxt = 1'b0;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
      fine_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      issued_r    <= issued_nxt;
      out_valid_r <= out_valid_nxt;
      fine_r      <= fine_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    raw_r      <= raw_nxt;
    rx_r       <= rx_nxt;
    ry_r       <= ry_nxt;
    rq_r       <= rq_nxt;
    rt_r       <= rt_nxt;
    rs_r       <= rs_nxt;
    rp_r       <= rp_nxt;
    res_val_r  <= res_val_nxt;
    res_bad_r  <= res_bad_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

>>> tb/tb_baro_temp_pressure_compensation_top.sv
// ----------------------------------------------------------------------------
// tb_baro_temp_pressure_compensation_top
// Self-checking bench for the barometric compensation block.
// ----------------------------------------------------------------------------
// A short stimulus table covers reset state, skip codes, the zero divisor and
// raw extremes. Random raw words then run under several coefficient sets,
// extremes included. Each result word is checked against the table or a Q24
// fixed-point model of the calibration formula in this bench. Both channels
// idle and stall in random bursts; one long receiver hold fills the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_baro_temp_pressure_compensation_top;
  import bptc_pkg::in_word_t;
  import bptc_pkg::out_word_t;
  import bptc_pkg::REG_TEMP_COEFFS;
  import bptc_pkg::REG_PRESS_LOW;
  import bptc_pkg::REG_PRESS_HIGH;
  import bptc_pkg::REG_PRESS_NINE;

  localparam longint Q1        = 64'sd1 <<< 24;
  localparam longint Q_TOP     = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam int     WDOG_MAX  = 4000;
  localparam int     HOLD_LEN  = 400;
  localparam int     PHASE_LEN = 260;

  typedef struct {
    logic [47:0] tc;
    logic [63:0] plo;
    logic [63:0] phi;
    logic [15:0] p9;
  } cal_set_t;

  typedef struct {
    bit        phase;   // 0: reset coefficients, 1: datasheet set
    in_word_t  w;
    bit        typed;
    out_word_t exp;
  } dir_row_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  in_word_t  in_data;
  out_word_t out_data;
  logic psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [63:0] pwdata, prdata;

  // model state
  logic [47:0] m_tc;
  logic [63:0] m_plo, m_phi;
  logic [15:0] m_p9;
  logic signed [31:0] fine_t;

  out_word_t expected_q[$];
  int  errors = 0;
  bit  quiet = 0;
  bit  hold_req = 0;
  int  idle_cnt = 0;
  cal_set_t cal_sets [5];

  dir_row_t dir_tab [18] = '{
    '{1'b0, '{1'b0, 8'h00, 8'h00, 8'h00}, 1'b1, '{1'b0, 32'sd0, 1'b0}},
    '{1'b0, '{1'b1, 8'h65, 8'h5A, 8'hC0}, 1'b1, '{1'b1, 32'sd0, 1'b1}},
    '{1'b0, '{1'b0, 8'h80, 8'h00, 8'h0F}, 1'b1, '{1'b0, 32'sd0, 1'b1}},
    '{1'b0, '{1'b1, 8'hFF, 8'hFF, 8'hF0}, 1'b1, '{1'b1, 32'sd0, 1'b1}},
    '{1'b0, '{1'b0, 8'hFF, 8'hFF, 8'hEF}, 1'b1, '{1'b0, 32'sd0, 1'b0}},
    '{1'b1, '{1'b1, 8'h65, 8'h5A, 8'hC0}, 1'b0, '{1'b0, 32'sd0, 1'b0}},
    '{1'b1, '{1'b0, 8'h7E, 8'hED, 8'h00}, 1'b0, '{1'b0, 32'sd0, 1'b0}},
    '{1'b1, '{1'b1, 8'h65, 8'h5A, 8'hC0}, 1'b0, '{1'b0, 32'sd0, 1'b0}},
    '{1'b1, '{1'b0, 8'h00, 8'h00, 8'h00}, 1'b0, '{1'b0, 32'sd0, 1'b0}},
    '{1'b1, '{1'b0, 8'hFF, 8'hFF, 8'hE0}, 1'b0, '{1'b0, 32'sd0, 1'b0}},
    '{1'b1, '{1'b1, 8'h00, 8'h00, 8'h00}, 1'b0, '{1'b0, 32'sd0, 1'b0}},
    '{1'b1, '{1'b1, 8'hFF, 8'hFF, 8'hEF}, 1'b0, '{1'b0, 32'sd0, 1'b0}},
    '{1'b1, '{1'b1, 8'h80, 8'h00, 8'h1F}, 1'b0, '{1'b0, 32'sd0, 1'b0}},
    '{1'b1, '{1'b0, 8'h7F, 8'hFF, 8'hFF}, 1'b0, '{1'b0, 32'sd0, 1'b0}},
    '{1'b1, '{1'b0, 8'h80, 8'h00, 8'h00}, 1'b1, '{1'b0, 32'sd0, 1'b1}},
    '{1'b1, '{1'b1, 8'hFF, 8'hFF, 8'hFF}, 1'b1, '{1'b1, 32'sd0, 1'b1}},
    '{1'b1, '{1'b0, 8'h12, 8'h34, 8'h56}, 1'b0, '{1'b0, 32'sd0, 1'b0}},
    '{1'b1, '{1'b1, 8'hAB, 8'hCD, 8'hEF}, 1'b0, '{1'b0, 32'sd0, 1'b0}}
  };

  baro_temp_pressure_compensation_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---- Q24 arithmetic ----
  function automatic logic [63:0] q_mag(input longint a);
    return a < 0 ? 64'(-a) : 64'(a);
  endfunction

  function automatic longint q_sat(input bit neg, input logic [63:0] m);
    logic [63:0] c;
    c = (m > 64'(Q_TOP)) ? 64'(Q_TOP) : m;
    return neg ? -longint'(c) : longint'(c);
  endfunction

  function automatic longint q_mul(input longint a, input longint b);
    logic [127:0] p;
    p = ({64'b0, q_mag(a)} * {64'b0, q_mag(b)}) >> 24;
    return q_sat((a < 0) != (b < 0), (p[127:64] != 0) ? '1 : p[63:0]);
  endfunction

  function automatic longint q_div(input longint n, input longint d);
    logic [127:0] num, quo;
    num = {64'b0, q_mag(n)} << 24;
    quo = num / {64'b0, q_mag(d)};
    return q_sat((n < 0) != (d < 0), (quo[127:64] != 0) ? '1 : quo[63:0]);
  endfunction

  // divide by 2^k toward zero
  function automatic longint q_shift(input longint a, input int k);
    return q_sat(a < 0, q_mag(a) >> k);
  endfunction

  function automatic longint q_sum(input longint a, input longint b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(Q_TOP)) return Q_TOP;
    if (s < -65'(Q_TOP)) return -Q_TOP;
    return longint'(s[63:0]);
  endfunction

  // ---- compensation model: one word in, one word out, updates fine_t ----
  function automatic out_word_t compensate(input in_word_t w);
    out_word_t r;
    longint raw, c1, c2, c3, da, db, pa, pb, tv;
    longint k1, k2, k3, k4, k5, k6, k7, k8, k9, x, y, s, q, lin, pr;
    raw = longint'({44'b0, w.raw_msb, w.raw_lsb, w.raw_xlsb[7:4]});
    r.result_kind = w.kind;
    r.value = 0;
    r.invalid = 1'b0;
    if (raw == 64'h80000 || raw == 64'hFFFFF) begin
      r.invalid = 1'b1;
    end else if (!w.kind) begin
      c1 = longint'({48'b0, m_tc[15:0]});
      c2 = longint'($signed(m_tc[31:16]));
      c3 = longint'($signed(m_tc[47:32]));
      da = (raw >>> 3) - c1 * 2;
      db = (raw >>> 4) - c1;
      pa = (da * c2) >>> 11;
      pb = (((db * db) >>> 12) * c3) >>> 14;
      fine_t = 32'(pa + pb);
      tv = (longint'(fine_t) * 5 + 128) >>> 8;
      r.value = 32'(tv);
    end else begin
      k1 = longint'({48'b0, m_plo[15:0]});
      k2 = longint'($signed(m_plo[31:16]));
      k3 = longint'($signed(m_plo[47:32]));
      k4 = longint'($signed(m_plo[63:48]));
      k5 = longint'($signed(m_phi[15:0]));
      k6 = longint'($signed(m_phi[31:16]));
      k7 = longint'($signed(m_phi[47:32]));
      k8 = longint'($signed(m_phi[63:48]));
      k9 = longint'($signed(m_p9));
      x = q_sum(q_shift(longint'(fine_t) * Q1, 1), -64000 * Q1);
      y = q_shift(q_mul(q_mul(x, x), k6 * Q1), 15);
      s = q_mul(x, k5 * Q1);
      y = q_sum(y, q_sum(s, s));
      y = q_sum(q_shift(y, 2), k4 * (Q1 <<< 16));
      q = q_shift(q_mul(q_mul(k3 * Q1, x), x), 19);
      lin = q_mul(k2 * Q1, x);
      x = q_shift(q_sum(q, lin), 19);
      x = q_mul(q_sum(Q1, q_shift(x, 15)), k1 * Q1);
      if (x == 0) begin
        r.invalid = 1'b1;
      end else begin
        pr = (1048576 - raw) * Q1;
        pr = q_div(q_mul(q_sum(pr, -q_shift(y, 12)), 6250 * Q1), x);
        q = q_shift(q_mul(q_mul(k9 * Q1, pr), pr), 31);
        lin = q_shift(q_mul(pr, k8 * Q1), 15);
        pr = q_sum(pr, q_shift(q_sum(q_sum(q, lin), k7 * Q1), 4));
        if (pr < 0) r.value = 0;
        else begin
          pr = pr >>> 16;
          r.value = (pr > 64'sh7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(pr);
        end
      end
    end
    return r;
  endfunction

  // ---- config port ----
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] v);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 3'b000}; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic load_cal(input cal_set_t c);
    write_reg(REG_TEMP_COEFFS, {16'b0, c.tc});
    write_reg(REG_PRESS_LOW, c.plo);
    write_reg(REG_PRESS_HIGH, c.phi);
    write_reg(REG_PRESS_NINE, {48'b0, c.p9});
    m_tc = c.tc; m_plo = c.plo; m_phi = c.phi; m_p9 = c.p9;
  endtask

  // let the block go idle before touching registers
  task automatic drain;
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // ---- input side ----
  task automatic offer_word(input in_word_t w, input bit typed, input out_word_t ex);
    out_word_t p;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    p = compensate(w);
    expected_q.push_back(typed ? ex : p);
  endtask

  task automatic maybe_idle;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic in_word_t pick_word();
    in_word_t w;
    logic [19:0] raw;
    int sel;
    w.kind = 1'($urandom_range(0, 1));
    sel = $urandom_range(0, 99);
    if (sel < 3) raw = 20'h80000;
    else if (sel < 6) raw = 20'hFFFFF;
    else if (sel < 50)
      raw = (w.kind ? 20'h655AC : 20'h7EED0) + 20'($urandom_range(0, 65535)) - 20'h8000;
    else raw = 20'($urandom);
    w.raw_msb  = raw[19:12];
    w.raw_lsb  = raw[11:4];
    w.raw_xlsb = {raw[3:0], 4'($urandom)};
    return w;
  endfunction

  function automatic cal_set_t rand_cal();
    cal_set_t c;
    c.tc  = {16'($urandom), 32'($urandom)};
    c.plo = {32'($urandom), 32'($urandom)};
    c.phi = {32'($urandom), 32'($urandom)};
    c.p9  = 16'($urandom);
    return c;
  endfunction

  // main stimulus
  initial begin
    bit cur_phase;
    cal_set_t ds;
    clk = 1'b0; rst_n = 1'b0;
    in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    m_tc = '0; m_plo = '0; m_phi = '0; m_p9 = '0; fine_t = '0;
    // datasheet-style coefficients
    ds.tc  = {16'hFC18, 16'd26435, 16'd27504};
    ds.plo = {16'd2855, 16'd3024, 16'hD641, 16'd36477};
    ds.phi = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
    ds.p9  = 16'd6000;
    cal_sets[0] = ds;
    cal_sets[1] = '{48'hFFFF_FFFF_FFFF, '1, '1, 16'hFFFF};
    cal_sets[2] = '{48'h7FFF_7FFF_FFFF, 64'h7FFF_7FFF_7FFF_FFFF,
                    64'h7FFF_7FFF_7FFF_7FFF, 16'h7FFF};
    cal_sets[3] = '{48'h8000_8000_0000, 64'h8000_8000_8000_0001,
                    64'h8000_8000_8000_8000, 16'h8000};
    cal_sets[4] = rand_cal();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    cur_phase = 1'b0;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].phase != cur_phase) begin
        drain();
        load_cal(ds);
        cur_phase = dir_tab[i].phase;
      end
      offer_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].exp);
      maybe_idle();
    end

    // random phases, one per coefficient set; last one runs without idling
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      load_cal(cal_sets[ph]);
      if (ph == 1) hold_req = 1'b1;
      quiet = (ph == 4);
      for (int n = 0; n < PHASE_LEN; n++) begin
        offer_word(pick_word(), 1'b0, '0);
        maybe_idle();
      end
    end

    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("tb_baro_temp_pressure_compensation_top OK");
    else $display("tb_baro_temp_pressure_compensation_top NOT OK");
    $finish;
  end

  // result side stall pattern
  initial begin
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        hold_req = 1'b0;
      end else if (quiet || $urandom_range(0, 2) != 0) begin
        out_stall <= 1'b0;
        repeat (quiet ? 1 : $urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  // result check against the oldest expected word
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result word %h", out_data);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_data.result_kind !== e.result_kind) begin
          $error("result_kind exp %0d got %0d", e.result_kind, out_data.result_kind);
          errors++;
        end
        if (out_data.value !== e.value) begin
          $error("value exp %0d got %0d", e.value, out_data.value);
          errors++;
        end
        if (out_data.invalid !== e.invalid) begin
          $error("invalid exp %0d got %0d", e.invalid, out_data.invalid);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel || !rst_n)
      idle_cnt <= 0;
    else if (idle_cnt >= WDOG_MAX) begin
      $display("tb_baro_temp_pressure_compensation_top NOT OK");
      $finish;
    end else
      idle_cnt <= idle_cnt + 1;
  end

endmodule
